// File: rtl/weighted_pagerank_engine_macros.svh
// Assertion macros for the weighted PageRank engine checker.
// Included by the checker file only; no other dependencies.
`ifndef WEIGHTED_PAGERANK_ENGINE_MACROS_SVH
`define WEIGHTED_PAGERANK_ENGINE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define WPR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define WPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/wpr_pkg.sv
// Shared types and constants for the weighted PageRank engine.
// No dependencies.
`default_nettype none
package wpr_pkg;
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;
    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_READ = 1'b1;
    localparam int RANK_W = 48;
    localparam int WSUM_W = 32;
    localparam int ACC_W  = 64;
    localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
    localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
    localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};
    localparam logic [1:0] CFG_ITER = 2'd0;
    localparam logic [1:0] CFG_NVTX = 2'd1;
    localparam logic [1:0] CFG_DAMP = 2'd2;
    // Divider handshake between sequencer and divider.
    typedef struct packed {
        logic              start;
        logic [RANK_W-1:0] dividend;
        logic [WSUM_W-1:0] divisor;
    } div_req_t;
    typedef struct packed {
        logic              done;
        logic [RANK_W-1:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/wpr_div.sv
// Bit-serial divider: floor(x * 2^WFB / s) saturated to 48 bits.
// Depends on wpr_pkg.
`default_nettype none
module wpr_div import wpr_pkg::*; #(
    parameter int WFB = 8
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire div_req_t req,
    output div_rsp_t rsp
);
    localparam int NW = RANK_W + WFB;
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0]     num_reg, num_next;
    logic [WSUM_W:0]   rem_reg, rem_next;
    logic [WSUM_W-1:0] den_reg, den_next;
    logic [NW-1:0]     quo_reg, quo_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [WSUM_W:0]   trial;

    always_comb begin
        num_next = num_reg; rem_next = rem_reg; den_next = den_reg;
        quo_next = quo_reg; cnt_next = cnt_reg; busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[WSUM_W-1:0], num_reg[NW-1]};
        if (req.start) begin
            num_next = {req.dividend, {WFB{1'b0}}};
            den_next = req.divisor;
            rem_next = '0;
            quo_next = '0;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
            if (req.divisor == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                quo_next = NW'(RANK_MAX);
            end
        end else if (busy_reg) begin
            num_next = {num_reg[NW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next; rem_reg <= rem_next; den_reg <= den_next;
        quo_reg <= quo_next; cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = (|quo_reg[NW-1:RANK_W]) ? RANK_MAX : quo_reg[RANK_W-1:0];
endmodule
`default_nettype wire

// File: rtl/weighted_pagerank_engine.sv
// Top level of the weighted PageRank engine: command channel, APB registers,
// edge and vertex memories and the run sequencer. Depends on wpr_pkg, wpr_div.
`default_nettype none
// Edge beats (opcode add) and clear beats are handled in the idle state and
// give no result; the next beat can be taken right after. A read beat reads
// the rank memory through a registered port; its result is loaded into the
// output register from the RDOUT state, which follows the READ state, and the
// next beat can be taken after that. A run beat walks the memories: it forms
// 1/n with a restoring divide, makes a clear pass over all MAX_VERTICES
// entries of the vertex tables and the ranks, reads, reads and writes back
// each stored edge for the out-weight sums, then steps per vertex through a
// read, a divide start and a wait and write, the wait lasting through the
// bit-serial division where the vertex has out-edges, to seed the ranks;
// each iteration clears the accumulators of the n vertices, walks the edges
// (read edge, read rank and accumulator, multiply, write, since each edge
// does a read-modify-write of its target accumulator with no overlap), and
// per vertex damps and, except in the last iteration, divides. Only one beat
// is in work at a time. A waiting result does not block the input: adds and
// clears go on, and a read or run holds at its end until the output register
// is free. The rank memory comes out of reset at zero through a clearing pass
// over all MAX_VERTICES entries, during which no beat is accepted.
module weighted_pagerank_engine import wpr_pkg::*; #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES = 8192,
    parameter int RANK_FRACTION_BITS = 32,
    parameter int WEIGHT_FRACTION_BITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [9:0]  s_source_vertex,
    input  wire logic [9:0]  s_target_vertex,
    input  wire logic [15:0] s_edge_weight,
    input  wire logic [9:0]  s_query_vertex,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_result_kind,
    output logic [47:0]      m_rank_value,
    output logic             m_dropped_store_full,
    output logic             m_dropped_bad_vertex
);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int CNT_W = 14;
    localparam logic [RANK_W-1:0] ONE_Q = RANK_W'(64'd1 << RANK_FRACTION_BITS);

    typedef enum logic [13:0] {
        ST_INIT  = 14'b00000000000001,
        ST_IDLE  = 14'b00000000000010,
        ST_READ  = 14'b00000000000100,
        ST_RDOUT = 14'b00000000001000,
        ST_SETUP = 14'b00000000010000,
        ST_VCLR  = 14'b00000000100000,
        ST_SUMS  = 14'b00000001000000,
        ST_SEED  = 14'b00000010000000,
        ST_NCLR  = 14'b00000100000000,
        ST_EDGE  = 14'b00001000000000,
        ST_VTX   = 14'b00010000000000,
        ST_DIV   = 14'b00100000000000,
        ST_DONE  = 14'b01000000000000,
        ST_ONEQ  = 14'b10000000000000
    } state_t;

    // configuration
    logic [7:0]  iter_cfg_reg;
    logic [10:0] nvtx_cfg_reg;
    logic [16:0] damp_cfg_reg;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_cfg_reg <= 8'd10;
            nvtx_cfg_reg <= 11'd1024;
            damp_cfg_reg <= 17'd55706;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                CFG_ITER: iter_cfg_reg <= pwdata[7:0];
                CFG_NVTX: nvtx_cfg_reg <= pwdata[10:0];
                CFG_DAMP: damp_cfg_reg <= pwdata[16:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            CFG_ITER: prdata = {24'd0, iter_cfg_reg};
            CFG_NVTX: prdata = {21'd0, nvtx_cfg_reg};
            CFG_DAMP: prdata = {15'd0, damp_cfg_reg};
            default:  prdata = '0;
        endcase
    end

    // effective vertex count and damping
    logic [NW-1:0] n_eff;
    logic [16:0]   d_eff;
    always_comb begin
        if (nvtx_cfg_reg == '0) n_eff = NW'(1);
        else if (32'(nvtx_cfg_reg) > MAX_VERTICES) n_eff = NW'(MAX_VERTICES);
        else n_eff = NW'(nvtx_cfg_reg);
        d_eff = (damp_cfg_reg > 17'd65536) ? 17'd65536 : damp_cfg_reg;
    end

    // memories
    logic [VW-1:0] esrc_mem [MAX_EDGES];
    logic [VW-1:0] etgt_mem [MAX_EDGES];
    logic [15:0]   ewt_mem  [MAX_EDGES];
    logic [WSUM_W-1:0] wsum_mem [MAX_VERTICES];
    logic              hasout_mem [MAX_VERTICES];
    logic [RANK_W-1:0] rank_mem [MAX_VERTICES];
    logic [ACC_W-1:0]  acc_mem  [MAX_VERTICES];

    state_t state_reg, state_next;
    logic [ETW-1:0] etot_reg;
    logic           drop_full_reg, drop_bad_reg;
    logic [EW-1:0]  eidx_reg;
    logic [NW-1:0]  vidx_reg;
    logic [1:0]     phase_reg;
    logic [7:0]     iter_reg;
    logic [RANK_W-1:0] one_reg;
    logic [NW-1:0]  n_reg;
    logic [16:0]    d_reg;
    logic [7:0]     niter_reg;
    logic [VW-1:0]  qv_reg;
    logic           qok_reg;

    // read data registers
    logic [VW-1:0]     esrc_rd, etgt_rd;
    logic [15:0]       ewt_rd;
    logic [WSUM_W-1:0] wsum_rd;
    logic              hasout_rd;
    logic [RANK_W-1:0] rank_rd;
    logic [ACC_W-1:0]  acc_rd;

    logic [EW-1:0] e_raddr;
    logic [VW-1:0] v_raddr;
    logic [VW-1:0] r_raddr;

    // pipeline registers for the edge and vertex steps
    logic [VW-1:0]     hold_s_reg, hold_t_reg;
    logic [15:0]       hold_w_reg;
    logic              hold_ok_reg;
    logic [RANK_W+15:0] prod_reg;
    logic [ACC_W-1:0]  dmp_hi_reg;
    logic [ACC_W-1:0]  dmp_lo_reg;
    logic [RANK_W-1:0] vrank_reg;

    // output register
    logic        m_valid_reg;
    logic        m_kind_reg;
    logic [47:0] m_rank_reg;
    logic        m_full_reg, m_bad_reg;
    logic        out_load;

    div_req_t dreq;
    div_rsp_t drsp;
    wpr_div #(.WFB(WEIGHT_FRACTION_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp)
    );

    logic s_fire;
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire = s_valid && s_ready;

    // result goes out once the output register is free or being taken
    assign out_load = ((state_reg == ST_RDOUT) || (state_reg == ST_DONE)) &&
                      (!m_valid_reg || m_ready);

    logic last_vtx, last_all, last_edge;
    assign last_vtx = (vidx_reg == n_reg - 1'b1);
    assign last_all = (vidx_reg == NW'(MAX_VERTICES - 1));
    assign last_edge = ({1'b0, eidx_reg} == ETW'(etot_reg - 1'b1)) ||
        (etot_reg == '0);

    // a vertex goes through the divider when it has out-edges, except in the
    // last iteration
    logic use_div, vtx_done;
    assign use_div = hasout_rd && ((state_reg == ST_SEED) || (iter_reg != niter_reg));
    assign vtx_done = (phase_reg == 2'd3) && (drsp.done || !use_div || !qok_reg);

    // damping arithmetic, registered between the multiplies and the final shift and add
    logic [ACC_W-1:0] dm_hi, dm_lo;
    logic [RANK_W-1:0] damped;
    always_comb begin
        damped = RANK_MAX;
        if (dmp_hi_reg <= ACC_W'(RANK_MAX >> 16)) begin
            if (((dmp_hi_reg << 16) + (dmp_lo_reg >> 16)) <= ACC_W'(RANK_MAX))
                damped = RANK_W'((dmp_hi_reg << 16) + (dmp_lo_reg >> 16));
        end
    end
    assign dm_hi = ACC_W'(d_reg) * ACC_W'(acc_rd[63:32]);
    assign dm_lo = ACC_W'(d_reg) * ACC_W'(acc_rd[31:0]) +
                   ACC_W'(17'd65536 - d_reg) * ACC_W'(one_reg);

    logic [ACC_W-1:0] p64, acc_sum;
    assign p64 = ACC_W'(prod_reg >> WEIGHT_FRACTION_BITS);
    assign acc_sum = (acc_rd > ACC_MAX - p64) ? ACC_MAX : acc_rd + p64;

    logic [WSUM_W:0] wsum_add;
    assign wsum_add = {1'b0, wsum_rd} + {17'd0, hold_w_reg};

    logic [NW-1:0] one_div_cnt;
    logic [RANK_W-1:0] one_rem;
    logic [RANK_W-1:0] one_trial;
    assign one_trial = {one_rem[RANK_W-2:0], ONE_Q[RANK_W-1 - 6'(one_div_cnt)]};

    always_comb begin
        e_raddr = eidx_reg;
        v_raddr = vidx_reg[VW-1:0];
        r_raddr = vidx_reg[VW-1:0];
        if (state_reg == ST_IDLE) r_raddr = s_query_vertex[VW-1:0];
        if (state_reg == ST_READ || state_reg == ST_RDOUT) r_raddr = qv_reg;
        dreq = '0;
        state_next = state_reg;
        case (state_reg)
            ST_INIT: if (last_vtx) state_next = ST_IDLE;
            ST_IDLE: if (s_fire) begin
                case (s_opcode)
                    OP_RUN:  state_next = ST_SETUP;
                    OP_READ: state_next = ST_READ;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_READ:  state_next = ST_RDOUT;
            ST_RDOUT: if (out_load) state_next = ST_IDLE;
            ST_SETUP: state_next = ST_ONEQ;
            ST_ONEQ:  if (one_div_cnt == NW'(RANK_W - 1)) state_next = ST_VCLR;
            ST_VCLR:  if (last_all) state_next = (etot_reg == '0) ? ST_SEED : ST_SUMS;
            ST_SUMS:  if (phase_reg == 2'd2 && last_edge) state_next = ST_SEED;
            ST_SEED, ST_VTX: begin
                if (phase_reg == 2'd2) begin
                    dreq.start = 1'b1;
                    dreq.divisor = wsum_rd;
                    dreq.dividend = (state_reg == ST_SEED) ? one_reg : damped;
                end
                if (vtx_done) begin
                    if (last_vtx) begin
                        if (iter_reg == niter_reg) state_next = ST_DONE;
                        else state_next = ST_NCLR;
                    end
                end
            end
            ST_NCLR: if (last_vtx) state_next = (etot_reg == '0) ? ST_VTX : ST_EDGE;
            ST_EDGE: if (phase_reg == 2'd3 && last_edge) state_next = ST_VTX;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_INIT;
        endcase
    end

    // memory ports
    always_ff @(posedge aclk) begin
        esrc_rd <= esrc_mem[e_raddr];
        etgt_rd <= etgt_mem[e_raddr];
        ewt_rd  <= ewt_mem[e_raddr];
        if (s_fire && s_opcode == OP_ADD && !(32'(s_source_vertex) >= 32'(n_eff) ||
            32'(s_target_vertex) >= 32'(n_eff)) && etot_reg < ETW'(MAX_EDGES)) begin
            esrc_mem[etot_reg[EW-1:0]] <= s_source_vertex[VW-1:0];
            etgt_mem[etot_reg[EW-1:0]] <= s_target_vertex[VW-1:0];
            ewt_mem[etot_reg[EW-1:0]]  <= s_edge_weight;
        end
    end

    // vertex-table address: sums use the held source, accumulation the target
    logic [VW-1:0] wv_addr, acc_addr;
    assign wv_addr = (state_reg == ST_SUMS) ? ((phase_reg == 2'd1) ? esrc_rd : hold_s_reg)
                                            : v_raddr;
    assign acc_addr = (state_reg == ST_EDGE) ? ((phase_reg == 2'd1) ? etgt_rd : hold_t_reg)
                                             : v_raddr;

    logic wsum_we, acc_we, rank_we;
    logic [VW-1:0] wsum_wa, acc_wa, rank_wa;
    logic [WSUM_W-1:0] wsum_wd;
    logic hasout_wd;
    logic [ACC_W-1:0] acc_wd;
    logic [RANK_W-1:0] rank_wd;
    logic [VW-1:0] rank_ra2;
    logic [RANK_W-1:0] vdone_rank;

    assign vdone_rank = (!qok_reg) ? '0 : (!use_div ? ((state_reg == ST_SEED) ?
        one_reg : vrank_reg) : drsp.quotient);

    always_comb begin
        wsum_we = 1'b0; wsum_wa = vidx_reg[VW-1:0]; wsum_wd = '0; hasout_wd = 1'b0;
        acc_we = 1'b0; acc_wa = vidx_reg[VW-1:0]; acc_wd = '0;
        rank_we = 1'b0; rank_wa = vidx_reg[VW-1:0]; rank_wd = '0;
        rank_ra2 = (state_reg == ST_EDGE) ? esrc_rd : r_raddr;
        case (state_reg)
            ST_INIT: rank_we = 1'b1;
            // every vertex: ranks beyond n read zero after a run
            ST_VCLR: begin
                wsum_we = 1'b1;
                rank_we = 1'b1;
            end
            ST_NCLR: acc_we = 1'b1;
            ST_SUMS: if (phase_reg == 2'd2 && hold_ok_reg) begin
                wsum_we = 1'b1; wsum_wa = hold_s_reg; hasout_wd = 1'b1;
                wsum_wd = wsum_add[WSUM_W] ? WSUM_MAX : wsum_add[WSUM_W-1:0];
            end
            ST_EDGE: if (phase_reg == 2'd3 && hold_ok_reg) begin
                acc_we = 1'b1; acc_wa = hold_t_reg; acc_wd = acc_sum;
            end
            ST_SEED, ST_VTX: if (vtx_done) begin
                rank_we = 1'b1; rank_wd = vdone_rank;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        wsum_rd   <= wsum_mem[wv_addr];
        hasout_rd <= hasout_mem[wv_addr];
        acc_rd    <= acc_mem[acc_addr];
        rank_rd   <= rank_mem[rank_ra2];
        if (wsum_we) begin
            wsum_mem[wsum_wa]   <= wsum_wd;
            hasout_mem[wsum_wa] <= hasout_wd;
        end
        if (acc_we) acc_mem[acc_wa] <= acc_wd;
        if (rank_we) rank_mem[rank_wa] <= rank_wd;
    end

    // sequencer registers
    logic [EW-1:0] eidx_p1;
    assign eidx_p1 = eidx_reg + 1'b1;
    always_ff @(posedge aclk) begin
        prod_reg <= rank_rd * (RANK_W+16)'(hold_w_reg);
        // accumulator read lands in phase 1
        if (state_reg == ST_VTX && phase_reg == 2'd1) begin
            dmp_hi_reg <= dm_hi;
            dmp_lo_reg <= dm_lo;
        end
        if (state_reg == ST_VTX && phase_reg == 2'd2) vrank_reg <= damped;
        if (out_load) begin
            m_full_reg <= drop_full_reg;
            m_bad_reg <= drop_bad_reg;
        end
        if (!aresetn) begin
            state_reg <= ST_INIT;
            etot_reg <= '0; drop_full_reg <= 1'b0; drop_bad_reg <= 1'b0;
            vidx_reg <= '0; eidx_reg <= '0; phase_reg <= '0; iter_reg <= '0;
            m_valid_reg <= 1'b0; n_reg <= NW'(MAX_VERTICES);
            one_div_cnt <= '0; one_rem <= '0; one_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_INIT: vidx_reg <= last_vtx ? '0 : vidx_reg + 1'b1;
                ST_IDLE: if (s_fire) begin
                    qv_reg <= s_query_vertex[VW-1:0];
                    qok_reg <= (32'(s_query_vertex) < 32'(n_eff));
                    n_reg <= n_eff; d_reg <= d_eff; niter_reg <= iter_cfg_reg;
                    case (s_opcode)
                        OP_ADD: begin
                            if (32'(s_source_vertex) >= 32'(n_eff) ||
                                32'(s_target_vertex) >= 32'(n_eff))
                                drop_bad_reg <= 1'b1;
                            else if (etot_reg >= ETW'(MAX_EDGES)) drop_full_reg <= 1'b1;
                            else etot_reg <= etot_reg + 1'b1;
                        end
                        OP_CLEAR: begin
                            etot_reg <= '0; drop_full_reg <= 1'b0; drop_bad_reg <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                ST_READ: ;
                ST_RDOUT: if (out_load) begin
                    m_kind_reg <= KIND_READ;
                    m_rank_reg <= qok_reg ? rank_rd : '0;
                end
                ST_SETUP: begin
                    vidx_reg <= '0; eidx_reg <= '0; phase_reg <= '0; iter_reg <= '0;
                    one_div_cnt <= '0; one_rem <= '0; one_reg <= '0;
                end
                ST_ONEQ: begin
                    // restoring division 2^F / n, one quotient bit a cycle
                    if (one_trial >= RANK_W'(n_reg)) begin
                        one_rem <= one_trial - RANK_W'(n_reg);
                        one_reg <= {one_reg[RANK_W-2:0], 1'b1};
                    end else begin
                        one_rem <= one_trial;
                        one_reg <= {one_reg[RANK_W-2:0], 1'b0};
                    end
                    one_div_cnt <= one_div_cnt + 1'b1;
                end
                ST_VCLR: begin
                    vidx_reg <= last_all ? '0 : vidx_reg + 1'b1;
                    eidx_reg <= '0; phase_reg <= '0;
                end
                ST_NCLR: begin
                    vidx_reg <= last_vtx ? '0 : vidx_reg + 1'b1;
                    eidx_reg <= '0; phase_reg <= '0;
                    if (last_vtx) iter_reg <= iter_reg + 1'b1;
                end
                ST_SUMS: begin
                    // phase 0 read edge, 1 read table, 2 write back
                    if (phase_reg == 2'd1) begin
                        hold_s_reg <= esrc_rd; hold_w_reg <= ewt_rd;
                        hold_ok_reg <= (32'(esrc_rd) < 32'(n_reg)) &&
                                       (32'(etgt_rd) < 32'(n_reg));
                    end
                    if (phase_reg == 2'd2) begin
                        phase_reg <= '0;
                        eidx_reg <= last_edge ? '0 : eidx_p1;
                    end else phase_reg <= phase_reg + 1'b1;
                end
                ST_EDGE: begin
                    // phase 0 read edge, 1 read rank and acc, 2 multiply, 3 write
                    if (phase_reg == 2'd1) begin
                        hold_t_reg <= etgt_rd; hold_w_reg <= ewt_rd;
                        hold_ok_reg <= (32'(esrc_rd) < 32'(n_reg)) &&
                                       (32'(etgt_rd) < 32'(n_reg));
                    end
                    phase_reg <= phase_reg + 1'b1;
                    if (phase_reg == 2'd3) eidx_reg <= last_edge ? '0 : eidx_p1;
                    if (phase_reg == 2'd3 && last_edge) vidx_reg <= '0;
                end
                ST_SEED, ST_VTX: begin
                    // phase 0 read, 1 damp (ST_VTX only), 2 start divide, 3 wait and write
                    qok_reg <= 1'b1;
                    if (phase_reg != 2'd3) phase_reg <= phase_reg + 1'b1;
                    if (vtx_done) begin
                        phase_reg <= '0;
                        vidx_reg <= last_vtx ? '0 : vidx_reg + 1'b1;
                    end
                end
                ST_DONE: if (out_load) begin
                    m_kind_reg <= KIND_RUN; m_rank_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_rank_value = m_rank_reg;
    assign m_dropped_store_full = m_full_reg;
    assign m_dropped_bad_vertex = m_bad_reg;
endmodule
`default_nettype wire

// File: rtl/wpr_checker.sv
// Port-level checker for the weighted PageRank engine, bound to the top level.
// Depends on weighted_pagerank_engine_macros.svh.
`default_nettype none
`include "weighted_pagerank_engine_macros.svh"
module wpr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_result_kind,
    input wire logic [47:0] m_rank_value,
    input wire logic        pready
);
    `WPR_ASSERT_IMP(a_run_zero, aclk, aresetn, m_valid && !m_result_kind, m_rank_value == '0)
    `WPR_ASSERT_NEXT(a_kind_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_result_kind))
    `WPR_ASSERT_IMP(a_pready, aclk, aresetn, 1'b1, pready)
    `WPR_ASSERT_NEXT(a_mhold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_rank_value))
endmodule

bind weighted_pagerank_engine wpr_checker u_wpr_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_valid(m_valid), .m_ready(m_ready), .m_result_kind(m_result_kind),
    .m_rank_value(m_rank_value), .pready(pready)
);
`default_nettype wire
